FILE: rtl/core/ipfpcv_pkg.sv
package ipfpcv_pkg;

    localparam int POS_W               = 17;
    localparam int MAX_FRAME_BYTES_DEF = 65536;
    localparam int OUT_DATA_W          = 136;

    localparam logic [15:0] ONES_ALL      = 16'hFFFF;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [3:0]  VERSION_FOUR  = 4'd4;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [6:0]  ETH_HDR_BYTES = 7'd14;
    localparam logic [6:0]  MIN_IP_END    = 7'd34;
    localparam logic [6:0]  TCP_MIN_HDR   = 7'd20;
    localparam logic [6:0]  UDP_HDR       = 7'd8;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_NOT_IPV4   = 4'd2;
    localparam logic [3:0] ST_SHORT_IP   = 4'd3;
    localparam logic [3:0] ST_BAD_VER    = 4'd4;
    localparam logic [3:0] ST_TCP_TRUNC  = 4'd5;
    localparam logic [3:0] ST_TCP_LEN    = 4'd6;
    localparam logic [3:0] ST_UDP_TRUNC  = 4'd7;
    localparam logic [3:0] ST_UDP_LEN    = 4'd8;
    localparam logic [3:0] ST_OTHER      = 4'd9;
    localparam logic [3:0] ST_CSUM_BAD   = 4'd10;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  ip_version;
        logic [3:0]  header_words;
        logic [7:0]  protocol;
        logic [15:0] total_length;
        logic [3:0]  tcp_offset;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_sum;
        logic [15:0] seg_sum;
        logic [15:0] pseudo_sum;
        logic [7:0]  held_byte;
    } frame_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

endpackage

FILE: rtl/core/ipv4_frame_parse_checksum_verify.sv
// Parses an Ethernet frame streamed one byte per transfer on the slave side (tlast on the
// final byte) and returns one result per frame on the master side: a status code, the IPv4
// addresses, the TCP/UDP ports, the payload offset and length, with the IP header and the
// transport checksum (pseudo-header included) verified on the fly. Bytes are taken every
// cycle; each byte only updates captured fields and folded ones'-complement sums. m_tvalid
// rises once the last byte has passed the input register, the end-of-frame snapshot and the
// output register. A last byte waits only while the previous frame's result still sits in
// the snapshot stage behind a stalled master side. Fields other than status read zero when
// status is not ok.
module ipv4_frame_parse_checksum_verify #(
    parameter int MAX_FRAME_BYTES = ipfpcv_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // frame_byte
    input  logic                              s_tlast,  // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[3:0], source_address[35:4], dest_address[67:36], source_port[83:68],
    // dest_port[99:84], payload_offset[116:100], payload_length[132:117], zeros above
    output logic [ipfpcv_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                              m_tuser   // is_tcp
);
    import ipfpcv_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] OVL_LEN = POS_W'(MAX_FRAME_BYTES + 1);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  in_fire;

    frame_t                frame_reg, frame_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  ovl_reg, ovl_next;

    logic                  snap_valid_reg, snap_valid_next;
    frame_t                snap_reg, snap_next;
    logic [POS_W-1:0]      snap_len_reg, snap_len_next;
    logic                  snap_ovl_reg, snap_ovl_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  out_free, snap_free, snap_move;
    logic                  take;
    logic [6:0]            ts_cur;
    logic [POS_W-1:0]      rel;
    logic                  in_ip, in_seg;
    logic [15:0]           word;
    frame_t                fr;

    assign out_free  = !m_valid_reg || m_tready;
    assign snap_move = snap_valid_reg && out_free;
    assign snap_free = !snap_valid_reg || out_free;
    assign in_fire   = in_valid_reg && (!in_last_reg || snap_free);
    assign s_tready  = !in_valid_reg || in_fire;

    // per-byte field capture and running sums
    always_comb begin
        fr       = frame_reg;
        pos_next = pos_reg;
        ovl_next = ovl_reg;
        take     = !ovl_reg && (pos_reg < MAX_POS);
        ts_cur   = '0;
        rel      = '0;
        in_ip    = 1'b0;
        in_seg   = 1'b0;
        word     = pos_reg[0] ? {frame_reg.held_byte, in_byte_reg} : {in_byte_reg, 8'h00};
        if (!ovl_reg && !take) begin
            ovl_next = 1'b1;
        end
        if (take) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(12) || pos_reg == POS_W'(13)) begin
                fr.ether_type = {fr.ether_type[7:0], in_byte_reg};
            end
            if (pos_reg == POS_W'(14)) begin
                fr.ip_version   = in_byte_reg[7:4];
                fr.header_words = in_byte_reg[3:0];
            end
            if (pos_reg == POS_W'(16) || pos_reg == POS_W'(17)) begin
                fr.total_length = {fr.total_length[7:0], in_byte_reg};
            end
            if (pos_reg == POS_W'(23)) begin
                fr.protocol   = in_byte_reg;
                fr.pseudo_sum = oc_add(fr.pseudo_sum, {8'h00, in_byte_reg});
            end
            if (pos_reg >= POS_W'(26) && pos_reg <= POS_W'(29)) begin
                fr.src_addr = {fr.src_addr[23:0], in_byte_reg};
            end
            if (pos_reg >= POS_W'(30) && pos_reg <= POS_W'(33)) begin
                fr.dst_addr = {fr.dst_addr[23:0], in_byte_reg};
            end
            if (pos_reg == POS_W'(27) || pos_reg == POS_W'(29) ||
                pos_reg == POS_W'(31) || pos_reg == POS_W'(33)) begin
                fr.pseudo_sum = oc_add(fr.pseudo_sum, word);
            end
            if (pos_reg >= POS_W'(ETH_HDR_BYTES)) begin
                ts_cur = ETH_HDR_BYTES + {1'b0, fr.header_words, 2'b00};
                in_ip  = pos_reg < POS_W'(ts_cur);
                in_seg = !in_ip;
                rel    = pos_reg - POS_W'(ts_cur);
                if (in_seg) begin
                    if (rel < POS_W'(2)) begin
                        fr.src_port = {fr.src_port[7:0], in_byte_reg};
                    end else if (rel < POS_W'(4)) begin
                        fr.dst_port = {fr.dst_port[7:0], in_byte_reg};
                    end else if (rel == POS_W'(12)) begin
                        fr.tcp_offset = in_byte_reg[7:4];
                    end
                end
                if (pos_reg[0] || in_last_reg) begin
                    if (in_ip) begin
                        fr.ip_sum = oc_add(fr.ip_sum, word);
                    end
                    if (in_seg) begin
                        fr.seg_sum = oc_add(fr.seg_sum, word);
                    end
                end
                if (!pos_reg[0]) begin
                    fr.held_byte = in_byte_reg;
                end
            end
        end
    end

    always_comb begin
        frame_next      = frame_reg;
        snap_next       = snap_reg;
        snap_len_next   = snap_len_reg;
        snap_ovl_next   = snap_ovl_reg;
        snap_valid_next = snap_valid_reg;
        if (snap_move) begin
            snap_valid_next = 1'b0;
        end
        if (in_fire) begin
            if (in_last_reg) begin
                snap_next       = fr;
                snap_len_next   = ovl_next ? OVL_LEN : pos_next;
                snap_ovl_next   = ovl_next;
                snap_valid_next = 1'b1;
                frame_next      = '0;
            end else begin
                frame_next = fr;
            end
        end
    end

    // end-of-frame checks
    logic [6:0]       snap_ts;
    logic [6:0]       snap_hw4;
    logic [6:0]       hdr_len;
    logic [3:0]       status;
    logic             is_tcp;
    logic [15:0]      csum;
    logic             ip_ok;
    logic             len_bad;
    logic [POS_W-1:0] seg_len;

    assign snap_hw4 = {1'b0, snap_reg.header_words, 2'b00};
    assign snap_ts  = ETH_HDR_BYTES + snap_hw4;
    assign seg_len  = snap_len_reg - POS_W'(snap_ts);
    assign csum     = oc_add(oc_add(snap_reg.seg_sum, snap_reg.pseudo_sum), seg_len[15:0]);
    assign ip_ok    = (snap_reg.header_words == 4'd0) || (snap_reg.ip_sum == ONES_ALL);
    assign len_bad  = snap_ovl_reg ||
                      ({1'b0, snap_reg.total_length} + POS_W'(ETH_HDR_BYTES) != snap_len_reg) ||
                      (snap_reg.total_length < 16'(snap_hw4) + 16'(hdr_len));

    always_comb begin
        is_tcp  = 1'b0;
        hdr_len = '0;
        if (snap_reg.protocol == PROTO_TCP) begin
            hdr_len = {1'b0, snap_reg.tcp_offset, 2'b00};
        end else if (snap_reg.protocol == PROTO_UDP) begin
            hdr_len = UDP_HDR;
        end
        priority if (snap_len_reg <= POS_W'(ETH_HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (snap_reg.ether_type != ETYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (snap_len_reg <= POS_W'(MIN_IP_END)) begin
            status = ST_SHORT_IP;
        end else if (snap_reg.ip_version != VERSION_FOUR) begin
            status = ST_BAD_VER;
        end else if (snap_reg.protocol == PROTO_TCP) begin
            is_tcp = 1'b1;
            if (POS_W'(snap_ts) + POS_W'(TCP_MIN_HDR) > snap_len_reg) begin
                status = ST_TCP_TRUNC;
            end else if (len_bad) begin
                status = ST_TCP_LEN;
            end else begin
                status = ST_OK;
            end
        end else if (snap_reg.protocol == PROTO_UDP) begin
            if (POS_W'(snap_ts) + POS_W'(UDP_HDR) > snap_len_reg) begin
                status = ST_UDP_TRUNC;
            end else if (len_bad) begin
                status = ST_UDP_LEN;
            end else begin
                status = ST_OK;
            end
        end else begin
            status = ST_OTHER;
        end
        if (status == ST_OK && (!ip_ok || csum != ONES_ALL)) begin
            status = ST_CSUM_BAD;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (snap_move) begin
            m_valid_next = 1'b1;
            m_tdata_next = '0;
            m_tuser_next = 1'b0;
            m_tdata_next[3:0] = status;
            if (status == ST_OK) begin
                m_tuser_next          = is_tcp;
                m_tdata_next[35:4]    = snap_reg.src_addr;
                m_tdata_next[67:36]   = snap_reg.dst_addr;
                m_tdata_next[83:68]   = snap_reg.src_port;
                m_tdata_next[99:84]   = snap_reg.dst_port;
                m_tdata_next[116:100] = POS_W'(snap_ts) + POS_W'(hdr_len);
                m_tdata_next[132:117] = snap_reg.total_length - 16'(snap_hw4) - 16'(hdr_len);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            frame_reg      <= '0;
            pos_reg        <= '0;
            ovl_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (in_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (in_fire) begin
                pos_reg <= (in_last_reg) ? '0 : pos_next;
                ovl_reg <= (in_last_reg) ? 1'b0 : ovl_next;
            end
            frame_reg      <= frame_next;
            snap_valid_reg <= snap_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        snap_reg     <= snap_next;
        snap_len_reg <= snap_len_next;
        snap_ovl_reg <= snap_ovl_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_last_fills_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last_reg) |=> snap_valid_reg)
        else $error("end of frame did not reach snapshot stage");

    a_pos_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last_reg) |=> (pos_reg == '0 && !ovl_reg))
        else $error("frame position not cleared after last byte");

    a_ovl_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ovl_reg |-> (pos_reg == MAX_POS))
        else $error("overlong flag without full position");

    a_fail_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tdata_reg[3:0] != ST_OK) |->
        (m_tdata_reg[OUT_DATA_W-1:4] == '0 && !m_tuser_reg))
        else $error("nonzero fields on failed frame");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ipfpcv_pkg::*;

    localparam int MAX_BYTES   = MAX_FRAME_BYTES_DEF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [3:0]  status;
        logic        is_tcp;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [16:0] pay_offset;
        logic [15:0] pay_length;
    } frame_result_t;

    typedef enum int {
        DMG_NONE, DMG_FLIP, DMG_ETYPE, DMG_VERSION, DMG_TRUNC, DMG_TOTLEN, DMG_PROTO,
        DMG_UDP_ZERO, DMG_APPEND, DMG_IHL_LOW, DMG_DOFF_MAX, DMG_NOISE
    } damage_t;

    class header_scoreboard;
        frame_result_t pending_results[$];
        int          errors;
        logic [16:0] byte_pos;
        logic [15:0] etype;
        logic [3:0]  version;
        logic [3:0]  hwords;
        logic [3:0]  tcp_words;
        logic [7:0]  proto;
        logic [15:0] tot_len;
        logic [31:0] addr[2];
        logic [15:0] port[2];
        logic [15:0] ip_sum;
        logic [15:0] seg_sum;
        logic [7:0]  hi_byte;
        bit          overlong;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] t;
            t = {1'b0, a} + {1'b0, b};
            if (t > 17'h0FFFF)
                t = t - 17'h0FFFF;
            return t[15:0];
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            etype     = '0;
            version   = '0;
            hwords    = '0;
            tcp_words = '0;
            proto     = '0;
            tot_len   = '0;
            addr[0]   = '0;
            addr[1]   = '0;
            port[0]   = '0;
            port[1]   = '0;
            ip_sum    = '0;
            seg_sum   = '0;
            hi_byte   = '0;
            overlong  = 1'b0;
        endfunction

        function void parse_byte(logic [7:0] b, bit last);
            int p;
            int ts;
            int rel;
            bit in_seg;
            logic [15:0] w;
            p = int'(byte_pos);
            if (p == 12 || p == 13)
                etype = {etype[7:0], b};
            if (p == 14) begin
                version = b[7:4];
                hwords  = b[3:0];
            end
            if (p == 16 || p == 17)
                tot_len = {tot_len[7:0], b};
            if (p == 23)
                proto = b;
            if (p >= 26 && p <= 29)
                addr[0] = {addr[0][23:0], b};
            if (p >= 30 && p <= 33)
                addr[1] = {addr[1][23:0], b};
            if (p < int'(ETH_HDR_BYTES))
                return;
            ts = int'(ETH_HDR_BYTES) + 4 * int'(hwords);
            in_seg = p >= ts;
            if (in_seg) begin
                rel = p - ts;
                if (rel < 2)
                    port[0] = {port[0][7:0], b};
                else if (rel < 4)
                    port[1] = {port[1][7:0], b};
                else if (rel == 12)
                    tcp_words = b[7:4];
            end
            if (p % 2 == 1) begin
                w = {hi_byte, b};
                if (in_seg)
                    seg_sum = ones_add(seg_sum, w);
                else
                    ip_sum = ones_add(ip_sum, w);
            end else begin
                hi_byte = b;
                if (last) begin
                    if (in_seg)
                        seg_sum = ones_add(seg_sum, {b, 8'h00});
                    else
                        ip_sum = ones_add(ip_sum, {b, 8'h00});
                end
            end
        endfunction

        // one accepted input transfer; a frame end queues the expected result
        function void accept_byte(logic [7:0] b, bit last);
            frame_result_t r;
            int len;
            int ts;
            int hdr;
            bit tcp;
            bit ip_ok;
            logic [3:0]  st;
            logic [15:0] s;
            if (!overlong) begin
                if (int'(byte_pos) >= MAX_BYTES) begin
                    overlong = 1'b1;
                end else begin
                    parse_byte(b, last);
                    byte_pos = byte_pos + 17'd1;
                end
            end
            if (!last)
                return;
            len = overlong ? MAX_BYTES + 1 : int'(byte_pos);
            ts  = int'(ETH_HDR_BYTES) + 4 * int'(hwords);
            hdr = 0;
            tcp = 1'b0;
            if (len <= int'(ETH_HDR_BYTES)) begin
                st = ST_SHORT;
            end else if (etype != ETYPE_IPV4) begin
                st = ST_NOT_IPV4;
            end else if (len <= int'(MIN_IP_END)) begin
                st = ST_SHORT_IP;
            end else if (version != VERSION_FOUR) begin
                st = ST_BAD_VER;
            end else if (proto == PROTO_TCP) begin
                tcp = 1'b1;
                hdr = 4 * int'(tcp_words);
                if (ts + int'(TCP_MIN_HDR) > len)
                    st = ST_TCP_TRUNC;
                else if (overlong || int'(tot_len) + int'(ETH_HDR_BYTES) != len ||
                         int'(tot_len) < 4 * int'(hwords) + hdr)
                    st = ST_TCP_LEN;
                else
                    st = ST_OK;
            end else if (proto == PROTO_UDP) begin
                hdr = int'(UDP_HDR);
                if (ts + hdr > len)
                    st = ST_UDP_TRUNC;
                else if (overlong || int'(tot_len) + int'(ETH_HDR_BYTES) != len ||
                         int'(tot_len) < 4 * int'(hwords) + hdr)
                    st = ST_UDP_LEN;
                else
                    st = ST_OK;
            end else begin
                st = ST_OTHER;
            end
            if (st == ST_OK) begin
                // pseudo-header folded into the segment sum
                s = ones_add(seg_sum, addr[0][31:16]);
                s = ones_add(s, addr[0][15:0]);
                s = ones_add(s, addr[1][31:16]);
                s = ones_add(s, addr[1][15:0]);
                s = ones_add(s, 16'(len - ts));
                s = ones_add(s, {8'h00, proto});
                ip_ok = hwords == 4'd0 || ip_sum == ONES_ALL;
                if (!ip_ok || s != ONES_ALL)
                    st = ST_CSUM_BAD;
            end
            r = '0;
            r.status = st;
            if (st == ST_OK) begin
                r.is_tcp     = tcp;
                r.src_addr   = addr[0];
                r.dst_addr   = addr[1];
                r.src_port   = port[0];
                r.dst_port   = port[1];
                r.pay_offset = 17'(ts + hdr);
                r.pay_length = 16'(int'(tot_len) - 4 * int'(hwords) - hdr);
            end
            pending_results.push_back(r);
            clear_frame();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
            frame_result_t e;
            if (pending_results.size() == 0) begin
                $error("result transfer with no frame outstanding, status %0d", data[3:0]);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            check_field("status", 32'(e.status), 32'(data[3:0]));
            check_field("is_tcp", 32'(e.is_tcp), 32'(user));
            check_field("source_address", e.src_addr, data[35:4]);
            check_field("dest_address", e.dst_addr, data[67:36]);
            check_field("source_port", 32'(e.src_port), 32'(data[83:68]));
            check_field("dest_port", 32'(e.dst_port), 32'(data[99:84]));
            check_field("payload_offset", 32'(e.pay_offset), 32'(data[116:100]));
            check_field("payload_length", 32'(e.pay_length), 32'(data[132:117]));
            check_field("tdata padding", 32'd0, 32'(data[OUT_DATA_W-1:133]));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    header_scoreboard hdr_sb = new();
    logic [7:0]       frame_buf[$];
    bit               calm = 1'b0;

    ipv4_frame_parse_checksum_verify dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [15:0] get16(int pos);
        return {frame_buf[pos], frame_buf[pos+1]};
    endfunction

    function automatic void put16(int pos, logic [15:0] v);
        frame_buf[pos]   = v[15:8];
        frame_buf[pos+1] = v[7:0];
    endfunction

    // big-endian pairs, a lone final byte padded with zero
    function automatic logic [15:0] fold_range(int from, int upto);
        logic [15:0] s;
        logic [7:0]  lo;
        int i;
        s = '0;
        for (i = from; i < upto; i += 2) begin
            lo = (i + 1 < upto) ? frame_buf[i+1] : 8'h00;
            s = header_scoreboard::ones_add(s, {frame_buf[i], lo});
        end
        return s;
    endfunction

    // fills in the ip header checksum (when ihl is at least three) and the transport checksum at csum_pos
    function automatic void seal(int csum_pos);
        int n;
        int ts;
        int ihl;
        logic [15:0] s;
        n   = frame_buf.size();
        ihl = int'(frame_buf[14][3:0]);
        ts  = 14 + 4 * ihl;
        if (ihl >= 3) begin
            put16(24, 16'h0000);
            put16(24, ~fold_range(14, ts));
        end
        put16(csum_pos, 16'h0000);
        s = fold_range(ts, n);
        s = header_scoreboard::ones_add(s, get16(26));
        s = header_scoreboard::ones_add(s, get16(28));
        s = header_scoreboard::ones_add(s, get16(30));
        s = header_scoreboard::ones_add(s, get16(32));
        s = header_scoreboard::ones_add(s, 16'(n - ts));
        s = header_scoreboard::ones_add(s, {8'h00, frame_buf[23]});
        put16(csum_pos, ~s);
    endfunction

    // well-formed frame with random content; ihl of at least five words
    function automatic void build_frame(logic [7:0] proto, int ihl, int thdr, int plen);
        int ts;
        int total;
        int i;
        ts    = 14 + 4 * ihl;
        total = 4 * ihl + thdr + plen;
        frame_buf.delete();
        for (i = 0; i < 14 + total; i++)
            frame_buf.push_back(8'($urandom));
        put16(12, ETYPE_IPV4);
        frame_buf[14] = {VERSION_FOUR, 4'(ihl)};
        put16(16, 16'(total));
        frame_buf[23] = proto;
        if (proto == PROTO_TCP) begin
            frame_buf[ts+12] = {4'(thdr / 4), frame_buf[ts+12][3:0]};
            seal(ts + 16);
        end else begin
            put16(ts + 4, 16'(thdr + plen));
            seal(ts + 6);
        end
    endfunction

    function automatic void trim(int keep);
        while (frame_buf.size() > keep)
            void'(frame_buf.pop_back());
    endfunction

    function automatic void damage(damage_t kind);
        int n;
        int ts;
        int k;
        int i;
        n  = frame_buf.size();
        ts = 14 + 4 * int'(frame_buf[14][3:0]);
        case (kind)
            DMG_FLIP: begin
                k = $urandom_range(14, n - 1);
                frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
            end
            DMG_ETYPE: begin
                put16(12, 16'($urandom));
            end
            DMG_VERSION: begin
                frame_buf[14] = {4'($urandom_range(0, 15)), frame_buf[14][3:0]};
            end
            DMG_TRUNC: begin
                trim($urandom_range(1, n - 1));
            end
            DMG_TOTLEN: begin
                if ($urandom_range(0, 1) == 1)
                    put16(16, get16(16) + 16'($urandom_range(1, 8)));
                else
                    put16(16, 16'($urandom));
            end
            DMG_PROTO: begin
                frame_buf[23] = 8'($urandom);
            end
            DMG_UDP_ZERO: begin
                if (frame_buf[23] == PROTO_UDP)
                    put16(ts + 6, 16'h0000);
            end
            DMG_APPEND: begin
                k = $urandom_range(1, 6);
                for (i = 0; i < k; i++)
                    frame_buf.push_back(8'($urandom));
            end
            DMG_IHL_LOW: begin
                frame_buf[14] = {frame_buf[14][7:4], 4'($urandom_range(0, 4))};
            end
            DMG_DOFF_MAX: begin
                if (frame_buf[23] == PROTO_TCP)
                    frame_buf[ts+12] = {4'hF, frame_buf[ts+12][3:0]};
            end
            DMG_NOISE: begin
                frame_buf.delete();
                k = $urandom_range(1, 60);
                for (i = 0; i < k; i++)
                    frame_buf.push_back(8'($urandom));
                if (k > 13 && $urandom_range(0, 1) == 1)
                    put16(12, ETYPE_IPV4);
                if (k > 14 && $urandom_range(0, 1) == 1)
                    frame_buf[14] = 8'h45;
                if (k > 23 && $urandom_range(0, 1) == 1)
                    frame_buf[23] = ($urandom_range(0, 1) == 1) ? PROTO_TCP : PROTO_UDP;
            end
            default: ;
        endcase
    endfunction

    task automatic send_frame();
        int n;
        int i;
        n = frame_buf.size();
        for (i = 0; i < n; i++) begin
            if (!calm && $urandom_range(0, 99) < 20) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_buf[i];
            s_tlast  <= (i == n - 1);
            do @(posedge aclk); while (!s_tready);
            hdr_sb.accept_byte(frame_buf[i], i == n - 1);
        end
    endtask

    // result side: check every transfer, stall at random
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                hdr_sb.check_result(m_tdata, m_tuser);
            m_tready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int k;
        int ts;
        int rand_bytes;
        int tcp;
        int ihl;
        int thdr;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // well-formed frames, option extremes, odd segment length
        build_frame(PROTO_TCP, 5, 20, 6);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 0);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 7);
        send_frame();
        build_frame(PROTO_TCP, 15, 60, 5);
        send_frame();
        // all-ones and all-zero addresses and ports
        for (k = 0; k < 2; k++) begin
            build_frame(PROTO_UDP, 5, 8, 4);
            put16(26, {16{k[0]}});
            put16(28, {16{k[0]}});
            put16(30, {16{k[0]}});
            put16(32, {16{k[0]}});
            put16(34, {16{k[0]}});
            put16(36, {16{k[0]}});
            seal(40);
            send_frame();
        end
        // too short for ethernet, then for ip; then not ipv4, then a bad version
        build_frame(PROTO_UDP, 5, 8, 2);
        trim(1);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 2);
        trim(14);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 2);
        trim(15);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 2);
        trim(34);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 4);
        put16(12, 16'h86DD);
        send_frame();
        build_frame(PROTO_TCP, 5, 20, 4);
        frame_buf[14] = 8'h65;
        send_frame();
        // no idling on either side for a stretch of frames
        calm = 1'b1;
        // tcp truncated, length mismatch, data offset past the segment
        build_frame(PROTO_TCP, 5, 20, 0);
        trim(44);
        send_frame();
        build_frame(PROTO_TCP, 5, 20, 10);
        put16(16, get16(16) + 16'd1);
        send_frame();
        build_frame(PROTO_TCP, 5, 20, 8);
        frame_buf[46] = {4'hF, frame_buf[46][3:0]};
        send_frame();
        // udp truncated, length mismatch, then a protocol other than tcp or udp
        build_frame(PROTO_UDP, 5, 8, 4);
        trim(38);
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 4);
        frame_buf.push_back(8'hA5);
        frame_buf.push_back(8'h5A);
        send_frame();
        build_frame(8'd1, 5, 8, 8);
        send_frame();
        calm = 1'b0;
        // bad transport checksum, bad ip header checksum, zero udp checksum
        build_frame(PROTO_UDP, 5, 8, 9);
        frame_buf[frame_buf.size()-1] = frame_buf[frame_buf.size()-1] ^ 8'h01;
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 6);
        frame_buf[18] = frame_buf[18] ^ 8'h01;
        send_frame();
        build_frame(PROTO_UDP, 5, 8, 6);
        put16(40, 16'h0000);
        send_frame();
        // header length below five words, sealed so that it can pass
        for (k = 0; k <= 4; k += 4) begin
            build_frame(PROTO_UDP, 5, 8, 10);
            frame_buf[14] = {VERSION_FOUR, 4'(k)};
            seal(frame_buf.size() - 2);
            send_frame();
        end
        build_frame(PROTO_UDP, 5, 8, 10);
        frame_buf[14] = 8'h42;
        send_frame();

        rand_bytes = 0;
        while (rand_bytes < 100) begin
            tcp  = $urandom_range(0, 1);
            ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
            if (tcp == 1)
                thdr = 4 * (($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5);
            else
                thdr = int'(UDP_HDR);
            build_frame((tcp == 1) ? PROTO_TCP : PROTO_UDP, ihl, thdr, $urandom_range(0, 24));
            if ($urandom_range(0, 99) >= 45)
                damage(damage_t'($urandom_range(int'(DMG_FLIP), int'(DMG_NOISE))));
            send_frame();
            rand_bytes += frame_buf.size();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (hdr_sb.outstanding() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (hdr_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ipfpcv_pkg.sv
rtl/core/ipv4_frame_parse_checksum_verify.sv
tb/tb.sv
